/* rtl/dwc_pkg.sv */
// Shared types and constants for the streaming depthwise 3x3 convolution.
// No dependencies; dwc_mac_cell and the stream top refer to it by scoped names.
`default_nettype none

package dwc_pkg;

   localparam int MaxWidth  = 64;
   localparam int LineAw    = $clog2(MaxWidth);
   localparam int DimW      = 7;
   localparam int NumTaps   = 9;
   localparam int AccW      = 36;
   localparam int FracShift = 12;

   typedef enum logic [3:0] {
      CSR_W_TOP    = 4'd0,
      CSR_W_MID    = 4'd1,
      CSR_W_BOT    = 4'd2,
      CSR_BIAS     = 4'd3,
      CSR_WIDTH    = 4'd4,
      CSR_HEIGHT   = 4'd5,
      CSR_STRIDE   = 4'd6,
      CSR_RELU     = 4'd7
   } csr_index_type;

   // one output position along an axis
   typedef struct packed {
      logic [5:0] idx;
      logic       shift;
      logic       pad_lo;
      logic       pad_hi;
      logic       last;
   } pos_type;

   typedef struct packed {
      logic [1:0]       n;
      pos_type [1:0]    e;
   } axis_type;

   // one convolution job travelling down the tap chain
   typedef struct packed {
      logic                          valid;
      logic [NumTaps-1:0][15:0]      ops;
      logic [NumTaps-1:0]            mask;
      logic signed [AccW-1:0]        acc;
      logic [5:0]                    row;
      logic [5:0]                    col;
      logic                          last;
   } job_type;

endpackage

`default_nettype wire

/* rtl/depthwise_conv3x3_stream.sv */
// An accepted item is registered in the accept stage and then in the job generator; each
// of its results then passes through the nine-cell tap chain and the result register.
// Throughput: one item per cycle while the output does not stall and no item has more
// than one result; an item with k results (k <= 4) holds the input until all are issued.
// Reset clears control, counters, window and configuration; line buffers are not cleared.
// Uses dwc_pkg, dwc_win_row and dwc_mac_cell.
`default_nettype none

module depthwise_conv3x3_stream (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_value,
   output logic [5:0]              rsp_out_row,
   output logic [5:0]              rsp_out_col,
   output logic                    rsp_plane_done,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [3:0]         csr_index,
   input  wire logic [47:0]        csr_data
);

   localparam int AccW = dwc_pkg::AccW;
   localparam int Aw   = dwc_pkg::LineAw;
   localparam int Dw   = dwc_pkg::DimW;

   // configuration
   logic [47:0]        wtop_ff, wmid_ff, wbot_ff;
   logic signed [15:0] bias_ff;
   logic [Dw-1:0]      width_ff, height_ff;
   logic [1:0]         stride_ff;
   logic               relu_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wtop_ff   <= '0;
         wmid_ff   <= '0;
         wbot_ff   <= '0;
         bias_ff   <= '0;
         width_ff  <= 7'd28;
         height_ff <= 7'd28;
         stride_ff <= 2'd1;
         relu_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (dwc_pkg::csr_index_type'(csr_index))
            dwc_pkg::CSR_W_TOP:  wtop_ff   <= csr_data;
            dwc_pkg::CSR_W_MID:  wmid_ff   <= csr_data;
            dwc_pkg::CSR_W_BOT:  wbot_ff   <= csr_data;
            dwc_pkg::CSR_BIAS:   bias_ff   <= csr_data[15:0];
            dwc_pkg::CSR_WIDTH:  width_ff  <= csr_data[Dw-1:0];
            dwc_pkg::CSR_HEIGHT: height_ff <= csr_data[Dw-1:0];
            dwc_pkg::CSR_STRIDE: stride_ff <= csr_data[1:0];
            dwc_pkg::CSR_RELU:   relu_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [Dw-1:0] w_eff, h_eff;
   logic          s2;

   always_comb begin
      w_eff = (width_ff < 7'd3) ? 7'd3 :
              (width_ff > Dw'(dwc_pkg::MaxWidth)) ? Dw'(dwc_pkg::MaxWidth) : width_ff;
      h_eff = (height_ff < 7'd3) ? 7'd3 : (height_ff > 7'd64) ? 7'd64 : height_ff;
      s2    = (stride_ff == 2'd2);
   end

   function automatic dwc_pkg::axis_type pick(logic [5:0] p, logic [6:0] lim, logic st2);
      dwc_pkg::axis_type a;
      dwc_pkg::pos_type  c0, c1;
      logic [6:0]        lm1, lastp;
      logic [5:0]        pm1;
      logic              v0, v1;
      lm1   = lim - 7'd1;
      lastp = st2 ? {lm1[6:1], 1'b0} : lm1;
      pm1   = p - 6'd1;
      v0    = (p != 6'd0) && (!st2 || p[0]);
      v1    = ({1'b0, p} == lm1) && (!st2 || !p[0]);
      c0.idx    = st2 ? {1'b0, pm1[5:1]} : pm1;
      c0.shift  = 1'b0;
      c0.pad_lo = (pm1 == 6'd0);
      c0.pad_hi = 1'b0;
      c0.last   = ({1'b0, pm1} == lastp);
      c1.idx    = st2 ? {1'b0, p[5:1]} : p;
      c1.shift  = 1'b1;
      c1.pad_lo = (p == 6'd0);
      c1.pad_hi = 1'b1;
      c1.last   = ({1'b0, p} == lastp);
      a.n    = {1'b0, v0} + {1'b0, v1};
      a.e[0] = v0 ? c0 : c1;
      a.e[1] = c1;
      return a;
   endfunction

   // accept stage: counters and line-buffer reads
   logic [5:0]        row_ff, col_ff, row_in, col_in;
   logic [5:0]        r_cur, c_cur;
   logic              req_acc, s1_move;
   dwc_pkg::axis_type rows_cur, cols_cur;

   assign req_acc = req_valid && !req_stall;

   always_comb begin
      r_cur = ({1'b0, row_ff} >= h_eff) ? 6'(h_eff - 7'd1) : row_ff;
      c_cur = ({1'b0, col_ff} >= w_eff) ? 6'(w_eff - 7'd1) : col_ff;
      rows_cur = pick(r_cur, h_eff, s2);
      cols_cur = pick(c_cur, w_eff, s2);
      row_in = row_ff;
      col_in = col_ff;
      if (req_acc) begin
         if ({1'b0, c_cur} >= 7'(w_eff - 7'd1)) begin
            col_in = '0;
            row_in = ({1'b0, r_cur} >= 7'(h_eff - 7'd1)) ? 6'd0 : r_cur + 6'd1;
         end else begin
            col_in = c_cur + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   logic [15:0] upper_mem  [dwc_pkg::MaxWidth];
   logic [15:0] middle_mem [dwc_pkg::MaxWidth];
   logic [15:0] up_rd_ff, mid_rd_ff;

   logic              s1_valid_ff;
   logic [15:0]       s1_sample_ff;
   logic [Aw-1:0]     s1_col_ff;
   dwc_pkg::axis_type s1_rows_ff, s1_cols_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         up_rd_ff  <= upper_mem[c_cur[Aw-1:0]];
         mid_rd_ff <= middle_mem[c_cur[Aw-1:0]];
      end
      if (s1_move) begin
         upper_mem[s1_col_ff]  <= mid_rd_ff;
         middle_mem[s1_col_ff] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc || (s1_valid_ff && !s1_move);
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_sample_ff <= req_sample;
         s1_col_ff    <= c_cur[Aw-1:0];
         s1_rows_ff   <= rows_cur;
         s1_cols_ff   <= cols_cur;
      end
   end

   // window
   logic [2:0][2:0][15:0] win;
   logic [2:0][15:0]      win_din;

   assign win_din = {s1_sample_ff, mid_rd_ff, up_rd_ff};

   for (genvar i = 0; i < 3; i++) begin : g_win
      dwc_win_row u_row (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_move),
         .din      (win_din[i]),
         .taps     (win[i])
      );
   end

   // job generator
   logic              adv;
   logic              gen_valid_ff, gen_valid_in;
   logic [1:0]        gen_ny_ff, gen_nx_ff;
   logic              gen_ia_ff, gen_ib_ff, gen_ia_in, gen_ib_in;
   dwc_pkg::axis_type gen_rows_ff, gen_cols_ff;
   logic              gen_last;
   dwc_pkg::pos_type  ry, cx;
   dwc_pkg::job_type  chain [dwc_pkg::NumTaps+1];

   assign gen_last  = (gen_ia_ff == gen_ny_ff[0]) && (gen_ib_ff == gen_nx_ff[0]);
   assign s1_move   = s1_valid_ff && (!gen_valid_ff || (adv && gen_last));
   assign req_stall = s1_valid_ff && !s1_move;

   always_comb begin
      gen_valid_in = gen_valid_ff;
      gen_ia_in    = gen_ia_ff;
      gen_ib_in    = gen_ib_ff;
      if (gen_valid_ff && adv) begin
         if (gen_last) begin
            gen_valid_in = 1'b0;
         end else if (gen_ib_ff == gen_nx_ff[0]) begin
            gen_ib_in = 1'b0;
            gen_ia_in = 1'b1;
         end else begin
            gen_ib_in = 1'b1;
         end
      end
      if (s1_move) begin
         gen_valid_in = (s1_rows_ff.n != 2'd0) && (s1_cols_ff.n != 2'd0);
         gen_ia_in    = 1'b0;
         gen_ib_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff <= 1'b0;
         gen_ia_ff    <= 1'b0;
         gen_ib_ff    <= 1'b0;
      end else begin
         gen_valid_ff <= gen_valid_in;
         gen_ia_ff    <= gen_ia_in;
         gen_ib_ff    <= gen_ib_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         gen_ny_ff   <= s1_rows_ff.n - 2'd1;
         gen_nx_ff   <= s1_cols_ff.n - 2'd1;
         gen_rows_ff <= s1_rows_ff;
         gen_cols_ff <= s1_cols_ff;
      end
   end

   always_comb begin
      logic [1:0] ri, cj;
      logic       ok;
      ry = gen_rows_ff.e[gen_ia_ff];
      cx = gen_cols_ff.e[gen_ib_ff];
      chain[0].valid = gen_valid_ff;
      chain[0].acc   = AccW'(bias_ff) <<< dwc_pkg::FracShift;
      chain[0].row   = ry.idx;
      chain[0].col   = cx.idx;
      chain[0].last  = ry.last && cx.last;
      chain[0].ops   = '0;
      chain[0].mask  = '0;
      for (int kh = 0; kh < 3; kh++) begin
         for (int kw = 0; kw < 3; kw++) begin
            ri = 2'(kh) + {1'b0, ry.shift};
            cj = 2'(kw) + {1'b0, cx.shift};
            ok = !(ry.shift && kh == 2) && !(cx.shift && kw == 2) &&
                 !(ry.pad_lo && kh == 0) && !(ry.pad_hi && kh == 2) &&
                 !(cx.pad_lo && kw == 0) && !(cx.pad_hi && kw == 2);
            chain[0].mask[kh*3+kw] = ok;
            if (ok) begin
               chain[0].ops[kh*3+kw] = win[ri][cj];
            end
         end
      end
   end

   // tap chain
   logic [dwc_pkg::NumTaps-1:0][15:0] wts;
   assign wts = {wbot_ff, wmid_ff, wtop_ff};

   for (genvar k = 0; k < dwc_pkg::NumTaps; k++) begin : g_tap
      dwc_mac_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .weight (wts[k]),
         .job_i  (chain[k]),
         .job_o  (chain[k+1])
      );
   end

   // round, saturate, relu, and hold the result
   logic                   rsp_valid_ff;
   logic signed [15:0]     value_ff, value_in;
   logic [5:0]             orow_ff, ocol_ff;
   logic                   done_ff;
   logic signed [AccW-1:0] rnd;
   logic signed [AccW-dwc_pkg::FracShift-1:0] q;

   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rnd = chain[dwc_pkg::NumTaps].acc + AccW'(2048);
      q   = rnd[AccW-1:dwc_pkg::FracShift];
      if (q > 24'sd32767) begin
         value_in = 16'sd32767;
      end else if (q < -24'sd32768) begin
         value_in = -16'sd32768;
      end else begin
         value_in = q[15:0];
      end
      if (relu_ff && value_in[15]) begin
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= chain[dwc_pkg::NumTaps].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_in;
         orow_ff  <= chain[dwc_pkg::NumTaps].row;
         ocol_ff  <= chain[dwc_pkg::NumTaps].col;
         done_ff  <= chain[dwc_pkg::NumTaps].last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_out_row    = orow_ff;
   assign rsp_out_col    = ocol_ff;
   assign rsp_plane_done = done_ff;

   a_gen_idx: assert property (@(posedge clock) disable iff (reset)
      gen_valid_ff |-> ({1'b0, gen_ia_ff} <= gen_ny_ff && {1'b0, gen_ib_ff} <= gen_nx_ff))
      else $error("generator index out of range");

   a_mem_rw: assert property (@(posedge clock) disable iff (reset)
      !(req_acc && s1_move && c_cur[Aw-1:0] == s1_col_ff))
      else $error("line buffer read and write collide");

   a_load: assert property (@(posedge clock) disable iff (reset)
      s1_move |-> (!gen_valid_ff || gen_last))
      else $error("generator reloaded while jobs remain");

endmodule

`default_nettype wire

/* rtl/dwc_win_row.sv */
// One row of the 3x3 window: three sample cells shifting left on each item.
// Depends on nothing.
`default_nettype none

module dwc_win_row (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire logic [15:0]       din,
   output logic      [2:0][15:0]  taps
);

   logic [2:0][15:0] cell_ff;
   logic [2:0][15:0] cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (shift_en) begin
         cell_in[0] = cell_ff[1];
         cell_in[1] = cell_ff[2];
         cell_in[2] = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign taps = cell_ff;

endmodule

`default_nettype wire

/* rtl/dwc_mac_cell.sv */
// Tap cell: multiplies the head operand of a job by its weight, accumulates it when
// the head mask bit is set, and hands the job on to the next cell. Uses dwc_pkg.
`default_nettype none

module dwc_mac_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic [15:0]      weight,
   input  wire dwc_pkg::job_type job_i,
   output dwc_pkg::job_type      job_o
);

   logic                             valid_ff;
   dwc_pkg::job_type                 job_ff;
   dwc_pkg::job_type                 job_in;
   logic signed [31:0]               prod;

   always_comb begin
      prod   = $signed(job_i.ops[0]) * $signed(weight);
      job_in = job_i;
      job_in.ops  = job_i.ops >> 16;
      job_in.mask = job_i.mask >> 1;
      if (job_i.mask[0]) begin
         job_in.acc = job_i.acc + dwc_pkg::AccW'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= job_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         job_ff <= job_in;
      end
   end

   always_comb begin
      job_o       = job_ff;
      job_o.valid = valid_ff;
   end

endmodule

`default_nettype wire

/* sim/depthwise_conv3x3_stream_check.sv */
// Checker for the depthwise 3x3 stream: watches the csr, req and rsp channels,
// predicts each output from its own copy of configuration and line state, and compares.
// Depends on dwc_pkg for the register index codes and MaxWidth.
`timescale 1ns / 1ps

module depthwise_conv3x3_stream_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_sample,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_value,
   input  logic [5:0]         rsp_out_row,
   input  logic [5:0]         rsp_out_col,
   input  logic               rsp_plane_done,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [47:0]        csr_data,
   output int                 errors,
   output int                 pending
);

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         row;
      logic [5:0]         col;
      logic               done;
   } conv_output_type;

   conv_output_type expected_outputs[$];

   logic [47:0]        w_top, w_mid, w_bot;
   logic signed [15:0] cfg_bias;
   logic [6:0]         cfg_width, cfg_height;
   logic [1:0]         cfg_stride;
   logic               cfg_relu;

   logic signed [15:0] upper_line [64];
   logic signed [15:0] middle_line [64];
   logic signed [15:0] win [3][3];
   int                 row_cnt, col_cnt;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic logic signed [15:0] tap_weight(input int kh, input int kw);
      logic [47:0] rowv;
      rowv = kh == 0 ? w_top : (kh == 1 ? w_mid : w_bot);
      return signed'(rowv[16*kw +: 16]);
   endfunction

   function automatic logic signed [15:0] conv_at(input int y, input int x, input int r,
                                                  input int c, input int h, input int w);
      longint acc;
      int     ir, ic, i, j;
      acc = longint'(cfg_bias) * 4096;
      for (int kh = 0; kh < 3; kh++) begin
         for (int kw = 0; kw < 3; kw++) begin
            ir = y - 1 + kh;
            ic = x - 1 + kw;
            i  = ir - r + 2;
            j  = ic - c + 2;
            if (ir >= 0 && ic >= 0 && ir < h && ic < w && i >= 0 && i <= 2 && j >= 0 && j <= 2)
               acc += longint'(win[i][j]) * longint'(tap_weight(kh, kw));
         end
      end
      acc = (acc + 2048) >>> 12;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      if (cfg_relu && acc < 0) acc = 0;
      return acc[15:0];
   endfunction

   task automatic predict_sample(input logic signed [15:0] smp);
      int w, h, s, r, c, ny, nx;
      int ys[2], xs[2];
      conv_output_type o;
      w = cfg_width < 3 ? 3 :
          (cfg_width > dwc_pkg::MaxWidth ? dwc_pkg::MaxWidth : int'(cfg_width));
      h = cfg_height < 3 ? 3 : (cfg_height > 64 ? 64 : int'(cfg_height));
      s = cfg_stride == 2 ? 2 : 1;
      if (col_cnt >= w) col_cnt = w - 1;
      if (row_cnt >= h) row_cnt = h - 1;
      r = row_cnt;
      c = col_cnt;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = smp;
      upper_line[c] = middle_line[c];
      middle_line[c] = smp;
      ny = 0;
      nx = 0;
      if (r >= 1 && (r - 1) % s == 0) ys[ny++] = r - 1;
      if (r == h - 1 && r % s == 0) ys[ny++] = r;
      if (c >= 1 && (c - 1) % s == 0) xs[nx++] = c - 1;
      if (c == w - 1 && c % s == 0) xs[nx++] = c;
      for (int a = 0; a < ny; a++) begin
         for (int b = 0; b < nx; b++) begin
            o.value = conv_at(ys[a], xs[b], r, c, h, w);
            o.row   = 6'(ys[a] / s);
            o.col   = 6'(xs[b] / s);
            o.done  = ys[a] == ((h - 1) / s) * s && xs[b] == ((w - 1) / s) * s;
            expected_outputs.push_back(o);
         end
      end
      if (c >= w - 1) begin
         col_cnt = 0;
         row_cnt = r >= h - 1 ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   always @(posedge clock) begin
      conv_output_type e;
      if (reset) begin
         w_top = '0;
         w_mid = '0;
         w_bot = '0;
         cfg_bias = '0;
         cfg_width = 7'd28;
         cfg_height = 7'd28;
         cfg_stride = 2'd1;
         cfg_relu = 1'b1;
         for (int i = 0; i < 64; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               win[i][j] = '0;
         row_cnt = 0;
         col_cnt = 0;
         expected_outputs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch("unexpected output count", 1, 0);
            end else begin
               e = expected_outputs.pop_front();
               if (rsp_value !== e.value) report_mismatch("value", rsp_value, e.value);
               if (rsp_out_row !== e.row) report_mismatch("out_row", rsp_out_row, e.row);
               if (rsp_out_col !== e.col) report_mismatch("out_col", rsp_out_col, e.col);
               if (rsp_plane_done !== e.done)
                  report_mismatch("plane_done", rsp_plane_done, e.done);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dwc_pkg::CSR_W_TOP:  w_top = csr_data;
               dwc_pkg::CSR_W_MID:  w_mid = csr_data;
               dwc_pkg::CSR_W_BOT:  w_bot = csr_data;
               dwc_pkg::CSR_BIAS:   cfg_bias = csr_data[15:0];
               dwc_pkg::CSR_WIDTH:  cfg_width = csr_data[6:0];
               dwc_pkg::CSR_HEIGHT: cfg_height = csr_data[6:0];
               dwc_pkg::CSR_STRIDE: cfg_stride = csr_data[1:0];
               dwc_pkg::CSR_RELU:   cfg_relu = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_sample(req_sample);
      end
      pending = expected_outputs.size();
   end

endmodule

/* sim/depthwise_conv3x3_stream_test.sv */
// Depthwise 3x3 stream testbench top: clock, reset, configuration writes, sample
// stimulus, idling and output stalls; uses dwc_pkg, the block and its checker.
`timescale 1ns / 1ps

module depthwise_conv3x3_stream_test;

   localparam int DrainCycles = 40;
   localparam int CycleLimit  = 600000;
   localparam int HoldCycles  = 400;
   localparam logic [3:0] CsrUnusedLo = 4'd8;
   localparam logic [3:0] CsrUnusedHi = 4'd15;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_value;
   logic [5:0]         rsp_out_row;
   logic [5:0]         rsp_out_col;
   logic               rsp_plane_done;
   logic               csr_valid;
   logic               csr_ready;
   logic [3:0]         csr_index;
   logic [47:0]        csr_data;
   int                 errors;
   int                 pending;
   int                 cycles;
   int                 idle_pct;
   int                 stall_pct;
   int                 hold_requests;
   int                 hold_seen;
   int                 hold_left;
   int                 random_items;

   depthwise_conv3x3_stream dut (.*);

   depthwise_conv3x3_stream_check checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   task automatic write_reg(input logic [3:0] idx, input logic [47:0] data);
      logic rdy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [15:0] v);
      logic stalled;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(511)) - 16'sd256;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] pick_weights();
      logic [47:0] v;
      v = {16'($urandom), 16'($urandom), 16'($urandom)};
      if ($urandom_range(1))
         for (int k = 0; k < 3; k++)
            v[16*k +: 16] = 16'($urandom_range(8191)) - 16'sd4096;
      return v;
   endfunction

   function automatic int clamp_dim(input logic [6:0] d);
      return d < 3 ? 3 : (d > 64 ? 64 : int'(d));
   endfunction

   task automatic wait_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic configure(input logic [47:0] wt, input logic [47:0] wm,
                            input logic [47:0] wb, input logic [15:0] b,
                            input logic [6:0] w, input logic [6:0] h,
                            input logic [1:0] s, input logic relu);
      write_reg(dwc_pkg::CSR_W_TOP, wt);
      write_reg(dwc_pkg::CSR_W_MID, wm);
      write_reg(dwc_pkg::CSR_W_BOT, wb);
      write_reg(dwc_pkg::CSR_BIAS, {32'($urandom), b});
      write_reg(dwc_pkg::CSR_WIDTH, {41'($urandom), w});
      write_reg(dwc_pkg::CSR_HEIGHT, {41'($urandom), h});
      write_reg(dwc_pkg::CSR_STRIDE, {46'($urandom), s});
      write_reg(dwc_pkg::CSR_RELU, {47'($urandom), relu});
   endtask

   task automatic run_plane(input int count, input bit extremes, input bit counted);
      for (int n = 0; n < count; n++) begin
         if (extremes)
            send_sample(n % 2 ? 16'sh8000 : 16'sh7fff);
         else
            send_sample(pick_sample());
         if (counted) random_items++;
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [6:0] w, h;
      int         plane;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      random_items = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure({16'h7fff, 16'h8000, 16'h7fff}, 48'hffff_ffff_ffff, 48'h8000_7fff_8000,
                16'h7fff, 7'd3, 7'd3, 2'd1, 1'b0);
      run_plane(9, 1, 0);
      wait_idle();
      configure(48'h1000_1000_1000, 48'h0000_f000_0000, 48'h7fff_0001_8000,
                16'h8000, 7'd0, 7'd2, 2'd0, 1'b1);
      run_plane(9, 0, 0);
      wait_idle();
      configure(pick_weights(), pick_weights(), pick_weights(), 16'h0080,
                7'd3, 7'd3, 2'd3, 1'b0);
      write_reg(CsrUnusedLo, {16'($urandom), 16'($urandom), 16'($urandom)});
      write_reg(CsrUnusedHi, 48'hffff_ffff_ffff);
      run_plane(9, 0, 0);
      wait_idle();

      // shrink the plane while its counters sit past the new edges
      configure(pick_weights(), pick_weights(), pick_weights(), 16'($urandom),
                7'd5, 7'd5, 2'd1, 1'b0);
      run_plane(19, 0, 1);
      wait_idle();
      write_reg(dwc_pkg::CSR_WIDTH, 48'd3);
      write_reg(dwc_pkg::CSR_HEIGHT, 48'd3);
      run_plane(1, 0, 1);
      wait_idle();

      plane = 0;
      while (random_items < 200) begin
         case (plane % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         w = 7'($urandom_range(3, 6));
         h = 7'($urandom_range(3, 5));
         if (plane == 3) begin
            w = 7'd127;
            h = 7'($urandom_range(0, 3));
         end
         configure(pick_weights(), pick_weights(), pick_weights(), 16'($urandom),
                   w, h, 2'($urandom_range(3)), 1'($urandom_range(1)));
         if (plane == 0) hold_requests++;
         run_plane(clamp_dim(w) * clamp_dim(h), 0, 1);
         wait_idle();
         plane++;
      end

      wait_idle();
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* depthwise_conv3x3_stream.f */
rtl/dwc_pkg.sv
rtl/dwc_win_row.sv
rtl/dwc_mac_cell.sv
rtl/depthwise_conv3x3_stream.sv
sim/depthwise_conv3x3_stream_check.sv
sim/depthwise_conv3x3_stream_test.sv
